FILE: design/tge_pkg.sv
// package for the task graph earliest start / latest finish engine
// types and constants shared by controller, datapath and top level
`default_nettype none
package tge_pkg;
  typedef enum logic [1:0] {
    OP_EDGE = 2'd0,
    OP_TASK = 2'd1,
    OP_RUN  = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam logic [1:0] REG_MOBILE = 2'd0;
  localparam logic [1:0] REG_CLOUD  = 2'd1;
  localparam logic [1:0] REG_BW     = 2'd2;
  localparam logic [1:0] REG_DL     = 2'd3;

  localparam logic signed [33:0] NO_CHILD = 34'sd6553600;
  localparam logic [31:0] Q_MAX = 32'h7fff_ffff;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FWD_RD,   // issue memory reads for pair (i,k)
    ST_FWD_DIV,  // run the divider(s)
    ST_FWD_ACC,  // fold candidate into best
    ST_BWD_RD,
    ST_BWD_DIV,
    ST_BWD_ACC,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       fwd_init;   // start forward task
    logic       bwd_init;
    logic       rd;         // read operands of pair
    logic       div_start;
    logic       acc;        // fold candidate
    logic       fwd_store;
    logic       bwd_store;
    logic       emit_rd;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic has_edge;
    logic need_xfer;
  } sts_t;
endpackage
`default_nettype wire

FILE: design/tge_div.sv
// restoring divider for q16.16 quotients: (num << 16) / den, saturated
// one quotient bit per cycle, uses tge_pkg
`default_nettype none
module tge_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] num,
  input  wire logic [15:0] den,
  output logic             done,
  output logic [31:0]      quo
);
  logic [31:0] q;
  logic [16:0] rem;
  logic [15:0] d;
  logic [5:0]  cnt;
  logic        busy;
  logic [16:0] trial;
  logic [16:0] sh;

  always_comb begin
    sh    = {rem[15:0], q[31]};
    trial = sh - {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        q    <= {num, 16'd0};
        rem  <= '0;
        d    <= den;
        if (den == 16'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
          q    <= tge_pkg::Q_MAX;
        end
      end else if (busy) begin
        if (!trial[16]) begin
          rem <= trial;
          q   <= {q[30:0], 1'b1};
        end else begin
          rem <= sh;
          q   <= {q[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient of 16.16 fits in 32 bits; bit 31 set means saturate
  assign quo = q[31] ? tge_pkg::Q_MAX : q;
endmodule
`default_nettype wire

FILE: design/tge_datapath.sv
// datapath: graph memories, time tables, two dividers and the max/min fold
// depends on tge_pkg and tge_div
`default_nettype none
module tge_datapath #(
  parameter int TASK_COUNT = 16,
  parameter int IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire tge_pkg::cmd_t  cmd,
  output tge_pkg::sts_t       sts,
  input  wire logic [IW-1:0]  cur_i,
  input  wire logic [IW-1:0]  cur_k,
  input  wire logic           load_edge,
  input  wire logic           load_task,
  input  wire logic [5:0]     ld_row,
  input  wire logic [5:0]     ld_col,
  input  wire logic [15:0]    ld_edge,
  input  wire logic [15:0]    ld_work,
  input  wire logic           ld_site,
  input  wire logic [15:0]    f_mobile,
  input  wire logic [15:0]    f_cloud,
  input  wire logic [15:0]    bw,
  input  wire logic [30:0]    dl,
  output logic [31:0]         est_q,
  output logic [31:0]         lft_q
);
  // edge store addressed as {row, col}, so one slot per index pair
  localparam int EW = 2 * IW;
  localparam int NE = 1 << EW;

  logic [15:0] emem [NE];
  logic [NE-1:0] evalid;
  logic [15:0] wmem [TASK_COUNT];
  logic [TASK_COUNT-1:0] sites;
  logic [31:0] smem [TASK_COUNT];
  logic [31:0] fmem [TASK_COUNT];

  logic [EW-1:0] eaddr, waddr;
  logic [15:0]   e_q, w_q;
  logic          site_i, site_k;
  logic [31:0]   t_k;     // start (fwd) or finish (bwd) of k
  logic          fwd_mode;
  logic signed [33:0] best, cand, best_fold;
  logic [31:0] comp_t, xfer_t;
  logic        d0_done, d1_done;
  logic [31:0] d0_q, d1_q;
  logic        c_ok, x_ok;
  logic signed [33:0] sum;

  assign waddr = {ld_row[IW-1:0], ld_col[IW-1:0]};
  assign eaddr = fwd_mode ? {cur_k, cur_i} : {cur_i, cur_k};

  always_ff @(posedge clk) begin
    if (rst) evalid <= '0;
    else if (load_edge) evalid[waddr] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (load_edge) emem[waddr] <= ld_edge;
    if (cmd.rd) e_q <= emem[eaddr];
  end

  logic ev_q;
  always_ff @(posedge clk) begin
    if (cmd.rd) ev_q <= evalid[eaddr];
  end

  always_ff @(posedge clk) begin
    if (rst) sites <= '0;
    else if (load_task) sites[ld_row[IW-1:0]] <= ld_site;
  end

  always_ff @(posedge clk) begin
    if (load_task) wmem[ld_row[IW-1:0]] <= ld_work;
    if (cmd.rd) begin
      w_q    <= wmem[cur_k];
      site_k <= sites[cur_k];
      site_i <= sites[cur_i];
      t_k    <= fwd_mode ? smem[cur_k] : fmem[cur_k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) fwd_mode <= 1'b1;
    else if (cmd.fwd_init) fwd_mode <= 1'b1;
    else if (cmd.bwd_init) fwd_mode <= 1'b0;
  end

  tge_div u_div0 (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(w_q),
    .den(site_k ? f_cloud : f_mobile), .done(d0_done), .quo(d0_q)
  );
  tge_div u_div1 (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(e_q),
    .den(bw), .done(d1_done), .quo(d1_q)
  );

  always_ff @(posedge clk) begin
    if (d0_done) comp_t <= d0_q;
    if (d1_done) xfer_t <= d1_q;
  end

  // a zero divisor finishes early, so wait for both quotients to be held
  always_ff @(posedge clk) begin
    if (rst) begin
      c_ok <= 1'b0;
      x_ok <= 1'b0;
    end else if (cmd.div_start) begin
      c_ok <= 1'b0;
      x_ok <= 1'b0;
    end else begin
      if (d0_done) c_ok <= 1'b1;
      if (d1_done) x_ok <= 1'b1;
    end
  end

  assign sts.div_done  = c_ok && x_ok;
  assign sts.has_edge  = ev_q && (e_q != 16'd0);
  assign sts.need_xfer = site_i != site_k;

  always_comb begin
    if (fwd_mode)
      sum = $signed({{2{t_k[31]}}, t_k}) + $signed({2'b00, comp_t})
          + (sts.need_xfer ? $signed({2'b00, xfer_t}) : 34'sd0);
    else
      sum = $signed({{2{t_k[31]}}, t_k}) - $signed({2'b00, comp_t})
          - (sts.need_xfer ? $signed({2'b00, xfer_t}) : 34'sd0);
    if (sum > 34'sh0_7fff_ffff) cand = 34'sh0_7fff_ffff;
    else if (sum < -34'sh0_8000_0000) cand = -34'sh0_8000_0000;
    else cand = sum;
  end

  // best including the candidate folded this cycle
  always_comb begin
    best_fold = best;
    if (cmd.acc && (fwd_mode ? (cand > best) : (cand < best))) best_fold = cand;
  end

  always_ff @(posedge clk) begin
    if (cmd.fwd_init) best <= '0;
    else if (cmd.bwd_init) best <= tge_pkg::NO_CHILD;
    else best <= best_fold;
  end

  always_ff @(posedge clk) begin
    if (cmd.fwd_store)
      smem[cur_i] <= (cur_i == '0) ? 32'd0 : best_fold[31:0];
    if (cmd.bwd_store)
      fmem[cur_i] <= (cur_i == IW'(TASK_COUNT - 1)) ? {1'b0, dl} : best_fold[31:0];
    if (cmd.emit_rd) begin
      est_q <= smem[cur_i];
      lft_q <= fmem[cur_i];
    end
  end
endmodule
`default_nettype wire

FILE: design/tge_ctrl.sv
// controller: sequences forward pass, backward pass and result emission
// depends on tge_pkg
`default_nettype none
module tge_ctrl #(
  parameter int TASK_COUNT = 16,
  parameter int IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          run,
  input  wire tge_pkg::sts_t sts,
  output tge_pkg::cmd_t      cmd,
  output logic [IW-1:0]      cur_i,
  output logic [IW-1:0]      cur_k,
  output logic               busy,
  output logic               emit_req,
  input  wire logic          emit_free
);
  localparam logic [IW-1:0] LAST = IW'(TASK_COUNT - 1);
  tge_pkg::state_t state, state_next;
  logic [IW-1:0] i_next, k_next;
  logic          em_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tge_pkg::ST_IDLE;
      cur_i <= '0;
      cur_k <= '0;
    end else begin
      state <= state_next;
      cur_i <= i_next;
      cur_k <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    i_next = cur_i;
    k_next = cur_k;
    cmd = '0;
    em_load = 1'b0;
    case (state)
      tge_pkg::ST_IDLE: begin
        if (run) begin
          cmd.fwd_init = 1'b1;
          i_next = '0;
          k_next = '0;
          state_next = tge_pkg::ST_FWD_RD;
        end
      end
      tge_pkg::ST_FWD_RD, tge_pkg::ST_BWD_RD: begin
        cmd.rd = 1'b1;
        state_next = (state == tge_pkg::ST_FWD_RD) ? tge_pkg::ST_FWD_DIV
                                                   : tge_pkg::ST_BWD_DIV;
        cmd.div_start = 1'b0;
      end
      tge_pkg::ST_FWD_DIV, tge_pkg::ST_BWD_DIV: begin
        // start both dividers once if the pair has an edge, then wait
        if (!sts.has_edge) begin
          state_next = (state == tge_pkg::ST_FWD_DIV) ? tge_pkg::ST_FWD_ACC
                                                      : tge_pkg::ST_BWD_ACC;
        end else begin
          cmd.div_start = 1'b1;
          state_next = (state == tge_pkg::ST_FWD_DIV) ? tge_pkg::ST_FWD_ACC
                                                      : tge_pkg::ST_BWD_ACC;
        end
      end
      tge_pkg::ST_FWD_ACC, tge_pkg::ST_BWD_ACC: begin
        if (!sts.has_edge || sts.div_done) begin
          cmd.acc = sts.has_edge;
          if (cur_k == LAST) begin
            k_next = '0;
            if (state == tge_pkg::ST_FWD_ACC) begin
              cmd.fwd_store = 1'b1;
              if (cur_i == LAST) begin
                cmd.bwd_init = 1'b1;
                i_next = LAST;
                state_next = tge_pkg::ST_BWD_RD;
              end else begin
                cmd.fwd_init = 1'b1;
                i_next = cur_i + 1'b1;
                state_next = tge_pkg::ST_FWD_RD;
              end
            end else begin
              cmd.bwd_store = 1'b1;
              if (cur_i == '0) begin
                state_next = tge_pkg::ST_EMIT;
              end else begin
                cmd.bwd_init = 1'b1;
                i_next = cur_i - 1'b1;
                state_next = tge_pkg::ST_BWD_RD;
              end
            end
          end else begin
            k_next = cur_k + 1'b1;
            state_next = (state == tge_pkg::ST_FWD_ACC) ? tge_pkg::ST_FWD_RD
                                                        : tge_pkg::ST_BWD_RD;
          end
        end
      end
      tge_pkg::ST_EMIT: begin
        if (emit_free) begin
          cmd.emit_rd = 1'b1;
          em_load = 1'b1;
          if (cur_i == LAST) begin
            state_next = tge_pkg::ST_IDLE;
          end else begin
            i_next = cur_i + 1'b1;
          end
        end
      end
      default: state_next = tge_pkg::ST_IDLE;
    endcase
  end

  assign busy = state != tge_pkg::ST_IDLE;
  assign emit_req = em_load;
endmodule
`default_nettype wire

FILE: design/task_graph_est_lft_top.sv
// top level of the task graph earliest start / latest finish engine
// depends on tge_pkg, tge_ctrl, tge_datapath, tge_div
//
//  channel | handshake          | word
//  in      | in_valid/in_ready  | operation, row_index, col_index, edge_data, task_work, site
//  cfg     | cfg_valid/cfg_ready| cfg_index, cfg_data
//  out     | out_valid/out_ready| task_index, earliest_start, latest_finish, last_of_run
//
// load words are accepted back to back while no run is busy
// a run walks every (i,k) pair in each pass; a pair with an edge waits for the
// 32-step serial dividers, a pair with no edge does not; then TASK_COUNT result
// words, each read only once the one before has left the time tables; a stalled
// receiver holds the emit state, and in and cfg stay stalled until the last
// word has been read from the time tables
// reset is synchronous; sites reset directly, edges clear through valid bits
`default_nettype none
module task_graph_est_lft_top #(
  parameter int TASK_COUNT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  operation,
  input  wire logic [5:0]  row_index,
  input  wire logic [5:0]  col_index,
  input  wire logic [15:0] edge_data,
  input  wire logic [15:0] task_work,
  input  wire logic        site,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       task_index,
  output logic signed [31:0] earliest_start,
  output logic signed [31:0] latest_finish,
  output logic             last_of_run
);
  localparam int IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

  logic [15:0] f_mobile, f_cloud, bw;
  logic [30:0] dl;
  tge_pkg::cmd_t cmd;
  tge_pkg::sts_t sts;
  logic [IW-1:0] cur_i, cur_k;
  logic busy, emit_req, emit_free, acc;
  logic [31:0] est_q, lft_q;
  logic        pend;
  logic [IW-1:0] pend_i;

  assign acc = in_valid && in_ready;
  assign in_ready = !busy;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_mobile <= 16'd500;
      f_cloud  <= 16'd3000;
      bw       <= 16'd50;
      dl       <= 31'd39322;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tge_pkg::REG_MOBILE: f_mobile <= cfg_data[15:0];
        tge_pkg::REG_CLOUD:  f_cloud  <= cfg_data[15:0];
        tge_pkg::REG_BW:     bw       <= cfg_data[15:0];
        tge_pkg::REG_DL:     dl       <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic ld_edge_ok, ld_task_ok;
  assign ld_edge_ok = acc && operation == tge_pkg::OP_EDGE
    && {1'b0, row_index} < 7'(TASK_COUNT) && {1'b0, col_index} < 7'(TASK_COUNT);
  assign ld_task_ok = acc && operation == tge_pkg::OP_TASK
    && {1'b0, row_index} < 7'(TASK_COUNT);

  tge_ctrl #(.TASK_COUNT(TASK_COUNT)) u_ctrl (
    .clk(clk), .rst(rst), .run(acc && operation == tge_pkg::OP_RUN),
    .sts(sts), .cmd(cmd), .cur_i(cur_i), .cur_k(cur_k), .busy(busy),
    .emit_req(emit_req), .emit_free(emit_free)
  );

  tge_datapath #(.TASK_COUNT(TASK_COUNT)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .cur_i(cur_i), .cur_k(cur_k),
    .load_edge(ld_edge_ok), .load_task(ld_task_ok), .ld_row(row_index),
    .ld_col(col_index), .ld_edge(edge_data), .ld_work(task_work),
    .ld_site(site), .f_mobile(f_mobile), .f_cloud(f_cloud), .bw(bw), .dl(dl),
    .est_q(est_q), .lft_q(lft_q)
  );

  // one word in flight from the time tables, one in the output register
  assign emit_free = !pend && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= emit_req;
      if (emit_req) pend_i <= cur_i;
      if (pend) begin
        out_valid <= 1'b1;
        task_index <= 6'(pend_i);
        earliest_start <= est_q;
        latest_finish <= lft_q;
        last_of_run <= pend_i == IW'(TASK_COUNT - 1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire
